[sv/phong_model_residual_accumulator_defines.svh]
// Assertion macros shared by the Phong residual accumulator RTL.
`ifndef PHONG_MODEL_RESIDUAL_ACCUMULATOR_DEFINES_SVH
`define PHONG_MODEL_RESIDUAL_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PMRA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PMRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pmra_pkg.sv]
// Types, constants and command codes of the Phong residual accumulator.
`timescale 1ns / 1ps
package pmra_pkg;

  localparam int COMP_W       = 16;
  localparam int VEC_W        = 3 * COMP_W;
  localparam int MUL_W        = 22;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DIR_ONE      = 16384;
  localparam int INV_PI_Q16   = 20861;
  localparam int MAX_EXPONENT = 127;
  localparam int EXP_W        = 7;
  localparam int SQRT_STEPS   = 26;
  localparam int DIV_STEPS    = 16;
  localparam int POW_BITS     = 7;
  localparam int COST_W       = 40;
  localparam int COUNT_W      = 16;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LIGHT_DIRECTION = 3'd0;
  localparam logic [2:0] CFG_DIRECT_COLOR    = 3'd1;
  localparam logic [2:0] CFG_DIFFUSE_ALBEDO  = 3'd2;
  localparam logic [2:0] CFG_SPECULAR_ALBEDO = 3'd3;
  localparam logic [2:0] CFG_LOBE_EXPONENT   = 3'd4;

  // Vector selects for normalization and operand pairs for dot products.
  localparam logic [1:0] VEC_L   = 2'd0;
  localparam logic [1:0] VEC_N   = 2'd1;
  localparam logic [1:0] VEC_V   = 2'd2;
  localparam logic [1:0] PAIR_NL = 2'd0;
  localparam logic [1:0] PAIR_RV = 2'd1;
  localparam logic [1:0] K_LAST  = 2'd2;

  typedef struct packed {
    logic [VEC_W-1:0] surface_normal;
    logic [VEC_W-1:0] view_direction;
    logic [VEC_W-1:0] measured_radiance;
    logic [VEC_W-1:0] ambient_irradiance;
    logic             last_sample;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0]  total_cost;
    logic [COUNT_W-1:0] sample_count;
  } out_item_t;

  typedef struct packed {
    logic [VEC_W-1:0] light_direction;
    logic [VEC_W-1:0] direct_color;
    logic [VEC_W-1:0] diffuse_albedo;
    logic [VEC_W-1:0] specular_albedo;
    logic [EXP_W-1:0] lobe_exponent;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_RT_INIT, OP_RT_STEP, OP_DV_INIT, OP_DV_STEP,
    OP_DV_STORE, OP_DOT, OP_DFIN, OP_REFL, OP_BFIN, OP_POW_MUL, OP_POW_SQR,
    OP_CH_LIT, OP_CH_IRR, OP_CH_DIF, OP_CH_SPC, OP_CH_RES, OP_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] vsel;
    logic [1:0] k;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

[sv/phong_model_residual_accumulator.sv]
// Top level of the Phong reflectance L1 residual accumulator.
// A new sample is accepted only after the previous one is accumulated, and a result
// beat is registered when the last sample of a set is accumulated. The bit-serial
// square root and the radix-2 divider (one quotient per component), run for the
// light, normal and view vectors around one shared multiplier, set the sample time.
// Synchronous reset restores register defaults, clears the sum and count, no flush.
`timescale 1ns / 1ps
`include "phong_model_residual_accumulator_defines.svh"
module phong_model_residual_accumulator import pmra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [VEC_W-1:0] cfg_data
);

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  pmra_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  pmra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pmra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (regs),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PMRA_ASSERT_SAME(a_accept_loads, in_valid && !in_stall, cmd.op == OP_LOAD, "accepted beat not loaded")
  `PMRA_ASSERT_NEXT(a_acc_releases, cmd.op == OP_ACC, !in_stall, "input still stalled after accumulate")
  `PMRA_ASSERT_SAME(a_result_from_acc, $rose(out_valid), $past(cmd.op == OP_ACC), "result without accumulate")

endmodule

[sv/pmra_cfg.sv]
// Configuration register bank of the Phong residual accumulator.
`timescale 1ns / 1ps
module pmra_cfg import pmra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [VEC_W-1:0] cfg_data,
  output cfg_regs_t        regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.light_direction <= VEC_W'(DIR_ONE);
      regs.direct_color    <= '0;
      regs.diffuse_albedo  <= '0;
      regs.specular_albedo <= '0;
      regs.lobe_exponent   <= EXP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_DIRECTION: regs.light_direction <= cfg_data;
        CFG_DIRECT_COLOR:    regs.direct_color    <= cfg_data;
        CFG_DIFFUSE_ALBEDO:  regs.diffuse_albedo  <= cfg_data;
        CFG_SPECULAR_ALBEDO: regs.specular_albedo <= cfg_data;
        CFG_LOBE_EXPONENT:   regs.lobe_exponent   <= cfg_data[EXP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/pmra_ctrl.sv]
// Sequencing state machine that walks the datapath through one sample.
`timescale 1ns / 1ps
module pmra_ctrl import pmra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_RT_INIT, S_RT_STEP, S_DV_INIT, S_DV_STEP, S_DV_STORE,
    S_DOT_D, S_DFIN, S_REFL, S_DOT_B, S_BFIN, S_POW_MUL, S_POW_SQR,
    S_CH_LIT, S_CH_IRR, S_CH_DIF, S_CH_SPC, S_CH_RES, S_ACC
  } state_t;

  localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);
  localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
  localparam logic [2:0] POW_LAST  = 3'(POW_BITS - 1);

  state_t     state;
  logic       stall;
  logic [1:0] k;
  logic [1:0] vsel;
  logic [2:0] idx;
  logic [4:0] cnt;
  logic       hold;

  // A last sample cannot retire while the previous result is still stalled.
  assign hold     = status.last && status.out_busy;
  assign in_stall = stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stall <= 1'b0;
      k     <= '0;
      vsel  <= VEC_L;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_SQ;
          stall <= 1'b1;
          k     <= '0;
          vsel  <= VEC_L;
        end
        S_SQ: if (k == K_LAST) begin
          k     <= '0;
          state <= S_RT_INIT;
        end else begin
          k <= k + 2'd1;
        end
        S_RT_INIT: begin
          cnt   <= '0;
          state <= S_RT_STEP;
        end
        S_RT_STEP: if (cnt == SQRT_LAST) begin
          state <= S_DV_INIT;
        end else begin
          cnt <= cnt + 5'd1;
        end
        S_DV_INIT: begin
          cnt   <= '0;
          state <= S_DV_STEP;
        end
        S_DV_STEP: if (cnt == DIV_LAST) begin
          state <= S_DV_STORE;
        end else begin
          cnt <= cnt + 5'd1;
        end
        S_DV_STORE: if (k != K_LAST) begin
          k     <= k + 2'd1;
          state <= S_DV_INIT;
        end else begin
          k <= '0;
          if (vsel != VEC_V) begin
            vsel  <= vsel + 2'd1;
            state <= S_SQ;
          end else begin
            vsel  <= VEC_L;
            state <= S_DOT_D;
          end
        end
        S_DOT_D: if (k == K_LAST) begin
          k     <= '0;
          state <= S_DFIN;
        end else begin
          k <= k + 2'd1;
        end
        S_DFIN: state <= S_REFL;
        S_REFL: if (k == K_LAST) begin
          k     <= '0;
          state <= S_DOT_B;
        end else begin
          k <= k + 2'd1;
        end
        S_DOT_B: if (k == K_LAST) begin
          k     <= '0;
          state <= S_BFIN;
        end else begin
          k <= k + 2'd1;
        end
        S_BFIN: begin
          idx   <= '0;
          state <= S_POW_MUL;
        end
        S_POW_MUL: state <= S_POW_SQR;
        S_POW_SQR: if (idx == POW_LAST) begin
          idx   <= '0;
          k     <= '0;
          state <= S_CH_LIT;
        end else begin
          idx   <= idx + 3'd1;
          state <= S_POW_MUL;
        end
        S_CH_LIT: state <= S_CH_IRR;
        S_CH_IRR: state <= S_CH_DIF;
        S_CH_DIF: state <= S_CH_SPC;
        S_CH_SPC: state <= S_CH_RES;
        S_CH_RES: if (k == K_LAST) begin
          k     <= '0;
          state <= S_ACC;
        end else begin
          k     <= k + 2'd1;
          state <= S_CH_LIT;
        end
        S_ACC: if (!hold) begin
          state <= S_IDLE;
          stall <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          stall <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.vsel = vsel;
    cmd.k    = k;
    cmd.idx  = idx;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_SQ:       cmd.op = OP_SQ;
      S_RT_INIT:  cmd.op = OP_RT_INIT;
      S_RT_STEP:  cmd.op = OP_RT_STEP;
      S_DV_INIT:  cmd.op = OP_DV_INIT;
      S_DV_STEP:  cmd.op = OP_DV_STEP;
      S_DV_STORE: cmd.op = OP_DV_STORE;
      S_DOT_D: begin
        cmd.op   = OP_DOT;
        cmd.vsel = PAIR_NL;
      end
      S_DFIN:     cmd.op = OP_DFIN;
      S_REFL:     cmd.op = OP_REFL;
      S_DOT_B: begin
        cmd.op   = OP_DOT;
        cmd.vsel = PAIR_RV;
      end
      S_BFIN:     cmd.op = OP_BFIN;
      S_POW_MUL:  cmd.op = OP_POW_MUL;
      S_POW_SQR:  cmd.op = OP_POW_SQR;
      S_CH_LIT:   cmd.op = OP_CH_LIT;
      S_CH_IRR:   cmd.op = OP_CH_IRR;
      S_CH_DIF:   cmd.op = OP_CH_DIF;
      S_CH_SPC:   cmd.op = OP_CH_SPC;
      S_CH_RES:   cmd.op = OP_CH_RES;
      S_ACC:      cmd.op = hold ? OP_NONE : OP_ACC;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

[sv/pmra_dp.sv]
// Datapath: shared multiplier, square root and divider steps, accumulator.
`timescale 1ns / 1ps
module pmra_dp import pmra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  cfg_regs_t  cfg,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  in_item_t smp;

  // Normalization state.
  logic [31:0] sq;
  logic [51:0] rad;
  logic [25:0] root;
  logic [27:0] rrem;
  logic [25:0] drem;
  logic [15:0] quo;

  logic signed [16:0] lu [3];
  logic signed [16:0] nu [3];
  logic signed [16:0] vu [3];
  logic signed [18:0] rv [3];

  logic signed [33:0] dacc;
  logic signed [17:0] d;
  logic [14:0]        base;
  logic [14:0]        pacc;
  logic [EXP_W-1:0]   expo;
  logic [18:0]        t1;
  logic [19:0]        shade;
  logic [21:0]        pred;
  logic [23:0]        rsum;
  logic [COST_W-1:0]  acc;
  logic [COUNT_W-1:0] cnt;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [VEC_W-1:0]  vword;
  logic [COMP_W-1:0] comp;
  logic [COMP_W-1:0] mag;
  logic [COMP_W-1:0] sun_k;
  logic [COMP_W-1:0] irr_k;
  logic [COMP_W-1:0] meas_k;
  logic [COMP_W-1:0] albd_k;
  logic [COMP_W-1:0] albs_k;
  logic [16:0]       lit;
  logic [29:0]       rt_sh;
  logic [29:0]       rt_trial;
  logic [26:0]       dv_sh;
  logic [16:0]       unit_val;
  logic signed [19:0] bval;
  logic [14:0]       bclamp;
  logic [21:0]       meas22;
  logic [21:0]       diff;
  logic [COST_W:0]   acc_sum;
  logic [COST_W-1:0] acc_next;
  logic [COUNT_W-1:0] cnt_next;

  always_comb begin
    unique case (cmd.vsel)
      VEC_L:   vword = cfg.light_direction;
      VEC_N:   vword = smp.surface_normal;
      default: vword = smp.view_direction;
    endcase
    comp   = vword[cmd.k*COMP_W +: COMP_W];
    mag    = comp[COMP_W-1] ? (~comp + 1'b1) : comp;
    sun_k  = cfg.direct_color[cmd.k*COMP_W +: COMP_W];
    albd_k = cfg.diffuse_albedo[cmd.k*COMP_W +: COMP_W];
    albs_k = cfg.specular_albedo[cmd.k*COMP_W +: COMP_W];
    irr_k  = smp.ambient_irradiance[cmd.k*COMP_W +: COMP_W];
    meas_k = smp.measured_radiance[cmd.k*COMP_W +: COMP_W];
    lit    = d[17] ? '0 : d[16:0];
  end

  // One shared signed multiplier; the ops that use it register the product (OP_POW_MUL only on a set exponent bit).
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(mag);
      end
      OP_DOT: if (cmd.vsel == PAIR_NL) begin
        mul_a = MUL_W'(nu[cmd.k]);
        mul_b = MUL_W'(lu[cmd.k]);
      end else begin
        mul_a = MUL_W'(rv[cmd.k]);
        mul_b = MUL_W'(vu[cmd.k]);
      end
      OP_REFL: begin
        mul_a = MUL_W'(d);
        mul_b = MUL_W'(nu[cmd.k]);
      end
      OP_POW_MUL: begin
        mul_a = MUL_W'(pacc);
        mul_b = MUL_W'(base);
      end
      OP_POW_SQR: begin
        mul_a = MUL_W'(base);
        mul_b = MUL_W'(base);
      end
      OP_CH_LIT: begin
        mul_a = MUL_W'(lit);
        mul_b = MUL_W'(sun_k);
      end
      OP_CH_IRR: begin
        mul_a = MUL_W'(irr_k);
        mul_b = MUL_W'(INV_PI_Q16);
      end
      OP_CH_DIF: begin
        mul_a = MUL_W'(albd_k);
        mul_b = MUL_W'(shade);
      end
      OP_CH_SPC: begin
        mul_a = MUL_W'(albs_k);
        mul_b = MUL_W'(pacc);
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    // Square root digit: bring down two radicand bits per step.
    rt_sh    = {rrem, rad[51:50]};
    rt_trial = {2'b00, root, 2'b01};
    // Restoring division: the remainder always stays below the root.
    dv_sh    = {drem, 1'b0};
    unit_val = comp[COMP_W-1] ? (~17'(quo) + 1'b1) : 17'(quo);
    if (sq == '0) begin
      unit_val = '0;
    end
    bval = dacc[33:14];
    if (bval[19]) begin
      bclamp = '0;
    end else if (bval[18:0] > 19'(DIR_ONE)) begin
      bclamp = 15'(DIR_ONE);
    end else begin
      bclamp = bval[14:0];
    end
    meas22   = 22'(meas_k);
    diff     = (meas22 >= pred) ? (meas22 - pred) : (pred - meas22);
    acc_sum  = {1'b0, acc} + (COST_W+1)'(rsum);
    acc_next = acc_sum[COST_W] ? '1 : acc_sum[COST_W-1:0];
    cnt_next = (cnt == '1) ? cnt : cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:    smp <= in_data;
      OP_SQ:      sq <= ((cmd.k == '0) ? '0 : sq) + prod[31:0];
      OP_RT_INIT: begin
        rad  <= {sq, 20'b0};
        root <= '0;
        rrem <= '0;
      end
      OP_RT_STEP: begin
        rad <= {rad[49:0], 2'b00};
        if (rt_sh >= rt_trial) begin
          rrem <= 28'(rt_sh - rt_trial);
          root <= {root[24:0], 1'b1};
        end else begin
          rrem <= rt_sh[27:0];
          root <= {root[24:0], 1'b0};
        end
      end
      OP_DV_INIT: begin
        drem <= 26'({mag, 8'b0});
        quo  <= '0;
      end
      OP_DV_STEP: if (dv_sh >= {1'b0, root}) begin
        drem <= 26'(dv_sh - {1'b0, root});
        quo  <= {quo[14:0], 1'b1};
      end else begin
        drem <= dv_sh[25:0];
        quo  <= {quo[14:0], 1'b0};
      end
      OP_DV_STORE: begin
        unique case (cmd.vsel)
          VEC_L:   lu[cmd.k] <= unit_val;
          VEC_N:   nu[cmd.k] <= unit_val;
          default: vu[cmd.k] <= unit_val;
        endcase
      end
      OP_DOT:     dacc <= ((cmd.k == '0) ? '0 : dacc) + prod[33:0];
      OP_DFIN:    d <= dacc[31:14];
      // Reflection term: floor(2 * d * n / 2^14) minus the light component.
      OP_REFL:    rv[cmd.k] <= prod[31:13] - 19'(lu[cmd.k]);
      OP_BFIN: begin
        base <= bclamp;
        pacc <= 15'(DIR_ONE);
        expo <= (cfg.lobe_exponent > EXP_W'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT)
                                                          : cfg.lobe_exponent;
      end
      OP_POW_MUL: if (expo[cmd.idx]) begin
        pacc <= prod[28:14];
      end
      OP_POW_SQR: base <= prod[28:14];
      OP_CH_LIT:  t1 <= prod[32:14];
      OP_CH_IRR:  shade <= 20'(t1) + 20'(prod[31:16]);
      OP_CH_DIF:  pred <= 22'(prod[35:15]);
      OP_CH_SPC:  pred <= pred + 22'(prod[30:17]);
      OP_CH_RES:  rsum <= ((cmd.k == '0) ? '0 : rsum) + 24'(diff);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (cmd.op == OP_ACC && smp.last_sample) begin
      out_data.total_cost   <= acc_next;
      out_data.sample_count <= cnt_next;
      out_valid             <= 1'b1;
      acc                   <= '0;
      cnt                   <= '0;
    end else begin
      if (cmd.op == OP_ACC) begin
        acc <= acc_next;
        cnt <= cnt_next;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.last     = smp.last_sample;
  assign status.out_busy = out_valid && out_stall;

endmodule

[sim/tb.sv]
// Self-checking testbench for the Phong reflectance residual accumulator.
`timescale 1ns / 1ps
module tb;
  import pmra_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int SETTLE_CYCLES = 320;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned COST_MAX = (64'd1 << COST_W) - 1;

  typedef longint vec3_t [3];

  typedef struct {
    bit              cfg_en;
    logic [2:0]      cfg_idx;
    logic [VEC_W-1:0] cfg_val;
    in_item_t        beat;
    bit              typed;
    longint unsigned cost;
    int unsigned     cnt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [VEC_W-1:0] cfg_data;

  cfg_regs_t model_regs;
  longint unsigned cost_sum;
  int unsigned samples_sum;
  out_item_t totals_q[$];
  stim_row_t dir_rows[$];
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  bit stall_phase = 1'b0;

  always #4 clk = ~clk;

  phong_model_residual_accumulator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= root + bitv) begin
        a -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic vec3_t normalize(input logic [VEC_W-1:0] w);
    vec3_t v;
    vec3_t u;
    longint unsigned mag [3];
    longint unsigned sq;
    longint unsigned len;
    longint q;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = longint'($signed(w[k*COMP_W +: COMP_W]));
      mag[k] = (v[k] < 0) ? longint'(-v[k]) : v[k];
      sq += mag[k] * mag[k];
    end
    if (sq == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return u;
    end
    len = int_sqrt(sq << 20);
    for (int k = 0; k < 3; k++) begin
      q = longint'((mag[k] << 24) / len);
      u[k] = (v[k] < 0) ? -q : q;
    end
    return u;
  endfunction

  function automatic longint dot14(input vec3_t a, input vec3_t b);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 14;
  endfunction

  // Adds one sample into the running residual sum; returns 1 when it closes a set.
  function automatic bit residual_step(input in_item_t s, output out_item_t total);
    vec3_t lu, nu, vu, rv;
    longint d, b;
    longint unsigned lit, lobe, base, sum, shade, pred, meas;
    int unsigned e;
    lu = normalize(model_regs.light_direction);
    nu = normalize(s.surface_normal);
    vu = normalize(s.view_direction);
    d = dot14(nu, lu);
    for (int k = 0; k < 3; k++) rv[k] = ((2 * d * nu[k]) >>> 14) - lu[k];
    b = dot14(rv, vu);
    if (b < 0) b = 0;
    if (b > DIR_ONE) b = DIR_ONE;
    e = model_regs.lobe_exponent;
    if (e > MAX_EXPONENT) e = MAX_EXPONENT;
    lobe = DIR_ONE;
    base = b;
    while (e != 0) begin
      if (e & 1) lobe = (lobe * base) >> 14;
      base = (base * base) >> 14;
      e >>= 1;
    end
    lit = (d > 0) ? d : 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      shade = ((lit * model_regs.direct_color[k*COMP_W +: COMP_W]) >> 14)
            + ((s.ambient_irradiance[k*COMP_W +: COMP_W] * INV_PI_Q16) >> 16);
      pred = ((model_regs.diffuse_albedo[k*COMP_W +: COMP_W] * shade) >> 15)
           + ((model_regs.specular_albedo[k*COMP_W +: COMP_W] * lobe) >> 17);
      meas = s.measured_radiance[k*COMP_W +: COMP_W];
      sum += (meas >= pred) ? meas - pred : pred - meas;
    end
    if (cost_sum > COST_MAX - sum || sum > COST_MAX) cost_sum = COST_MAX;
    else cost_sum += sum;
    if (samples_sum < 65535) samples_sum++;
    total = '0;
    if (!s.last_sample) return 1'b0;
    total.total_cost = cost_sum[COST_W-1:0];
    total.sample_count = samples_sum[COUNT_W-1:0];
    cost_sum = 0;
    samples_sum = 0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [VEC_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LIGHT_DIRECTION: model_regs.light_direction = val;
      CFG_DIRECT_COLOR:    model_regs.direct_color = val;
      CFG_DIFFUSE_ALBEDO:  model_regs.diffuse_albedo = val;
      CFG_SPECULAR_ALBEDO: model_regs.specular_albedo = val;
      CFG_LOBE_EXPONENT:   model_regs.lobe_exponent = val[EXP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A sample with no result may still be in flight, so let it drain fully.
  task automatic wait_idle();
    while (totals_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(input in_item_t s, input bit typed, input out_item_t typed_total);
    out_item_t total;
    int gap;
    in_data <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    beats_sent++;
    if (residual_step(s, total)) totals_q.insert(totals_q.size(), typed ? typed_total : total);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [VEC_W-1:0] rand_dir();
    int r;
    logic [VEC_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return VEC_W'({$urandom(), $urandom()});
    if (r < 30) return {3{16'h8000}};
    for (int k = 0; k < 3; k++)
      w[k*COMP_W +: COMP_W] = 16'($signed($urandom_range(0, 32768)) - 16384);
    return w;
  endfunction

  function automatic logic [VEC_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VEC_W'({$urandom(), $urandom()});
  endfunction

  function automatic in_item_t make_beat(input logic [VEC_W-1:0] n, input logic [VEC_W-1:0] v,
                                         input logic [VEC_W-1:0] m, input logic [VEC_W-1:0] a,
                                         input logic last);
    in_item_t s;
    s.surface_normal = n;
    s.view_direction = v;
    s.measured_radiance = m;
    s.ambient_irradiance = a;
    s.last_sample = last;
    return s;
  endfunction

  task automatic add_row(input bit cen, input logic [2:0] idx, input logic [VEC_W-1:0] val,
                         input in_item_t s, input bit typed, input longint unsigned cost,
                         input int unsigned cnt);
    stim_row_t row;
    row.cfg_en = cen;
    row.cfg_idx = idx;
    row.cfg_val = val;
    row.beat = s;
    row.typed = typed;
    row.cost = cost;
    row.cnt = cnt;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic build_directed();
    localparam logic [VEC_W-1:0] X_POS = 48'h0000_0000_4000;
    localparam logic [VEC_W-1:0] X_NEG = 48'h0000_0000_C000;
    localparam logic [VEC_W-1:0] ALL1 = '1;
    // Reset config: albedos are zero, so the cost is just the measured radiance.
    add_row(0, 0, 0, make_beat(0, 0, 48'h0003_0002_0001, 0, 1), 1, 6, 1);
    add_row(0, 0, 0, make_beat(ALL1, {3{16'h8000}}, ALL1, ALL1, 0), 0, 0, 0);
    add_row(0, 0, 0, make_beat(X_NEG, X_POS, 0, 0, 1), 1, 196605, 2);
    add_row(1, CFG_DIRECT_COLOR, {3{16'h1000}}, make_beat(X_POS, X_POS, 0, 0, 1), 0, 0, 0);
    add_row(1, CFG_DIFFUSE_ALBEDO, {3{16'h4000}},
            make_beat(X_POS, X_POS, {3{16'h0800}}, {3{16'h1000}}, 1), 0, 0, 0);
    add_row(1, CFG_SPECULAR_ALBEDO, {3{16'h8000}}, make_beat(X_POS, X_POS, 0, 0, 1), 0, 0, 0);
    // Normal facing away: negative N.L, while the lobe base is at its full value.
    add_row(0, 0, 0, make_beat(X_NEG, X_POS, 48'h0100_0200_0300, 0, 1), 0, 0, 0);
    // Exponent written with bits above its width; only the low seven count.
    add_row(1, CFG_LOBE_EXPONENT, 48'hFFFF_FFFF_FF80,
            make_beat(48'h0000_2000_2000, 48'h1000_0000_3000, 0, 0, 1), 0, 0, 0);
    add_row(1, CFG_LOBE_EXPONENT, 48'd127,
            make_beat(48'h0000_2000_2000, 48'h0000_0000_4000, 0, 0, 1), 0, 0, 0);
    add_row(1, 3'd5, ALL1, make_beat(X_POS, 48'h0000_4000_4000, 0, ALL1, 1), 0, 0, 0);
    add_row(1, 3'd7, 0, make_beat(48'h1234_7FFF_8001, 48'h7FFF_7FFF_7FFF, ALL1, 0, 0),
            0, 0, 0);
    add_row(1, CFG_LIGHT_DIRECTION, 0, make_beat(X_POS, X_POS, 48'h0001_0001_0001, 0, 1),
            0, 0, 0);
    add_row(1, CFG_LIGHT_DIRECTION, 48'h7FFF_8000_7FFF,
            make_beat(48'h4000_0000_4000, 48'h4000_4000_0000, 0, ALL1, 1), 0, 0, 0);
    add_row(1, CFG_DIRECT_COLOR, ALL1, make_beat(48'h4000_0000_4000, X_POS, ALL1, ALL1, 0),
            0, 0, 0);
    add_row(1, CFG_DIFFUSE_ALBEDO, ALL1, make_beat(48'h7FFF_7FFF_7FFF, 0, 0, ALL1, 0), 0, 0, 0);
    add_row(1, CFG_SPECULAR_ALBEDO, ALL1, make_beat(48'h3000_1000_2000, 48'h4000_4000_4000,
            48'h8000_0001_FFFF, 48'h0001_8000_FFFF, 1), 0, 0, 0);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (no_idle || stall_phase) begin
      stall_phase <= 1'b0;
      out_stall <= 1'b0;
      stall_left <= $urandom_range(1, 20);
    end else begin
      stall_phase <= 1'b1;
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (totals_q.size() == 0) begin
        $error("unexpected result beat: total_cost %0d sample_count %0d",
               out_data.total_cost, out_data.sample_count);
        errors++;
      end else begin
        if (out_data.total_cost !== totals_q[0].total_cost) begin
          $error("total_cost: expected %0d, actual %0d", totals_q[0].total_cost,
                 out_data.total_cost);
          errors++;
        end
        if (out_data.sample_count !== totals_q[0].sample_count) begin
          $error("sample_count: expected %0d, actual %0d", totals_q[0].sample_count,
                 out_data.sample_count);
          errors++;
        end
        void'(totals_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_item_t typed_total;
    int sent;
    int set_left;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    model_regs.light_direction = 48'd16384;
    model_regs.direct_color = '0;
    model_regs.diffuse_albedo = '0;
    model_regs.specular_albedo = '0;
    model_regs.lobe_exponent = 7'd1;
    cost_sum = 0;
    samples_sum = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_directed();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_en) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
        end_writes();
      end
      typed_total.total_cost = dir_rows[i].cost[COST_W-1:0];
      typed_total.sample_count = dir_rows[i].cnt[COUNT_W-1:0];
      send_beat(dir_rows[i].beat, dir_rows[i].typed, typed_total);
    end

    sent = 0;
    set_left = 0;
    while (sent < RANDOM_ITEMS) begin
      // New register settings every so often, always between whole sets.
      if (set_left == 0 && sent % 120 == 0 && sent > 0) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(CFG_LIGHT_DIRECTION, rand_dir());
        write_reg(CFG_DIRECT_COLOR, rand_word());
        write_reg(CFG_DIFFUSE_ALBEDO, rand_word());
        write_reg(CFG_SPECULAR_ALBEDO, rand_word());
        write_reg(CFG_LOBE_EXPONENT, ($urandom_range(0, 3) == 0) ?
                  VEC_W'({$urandom(), $urandom()}) : VEC_W'($urandom_range(0, 12)));
        end_writes();
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (set_left == 0)
        set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      set_left--;
      send_beat(make_beat(rand_dir(), rand_dir(), rand_word(), rand_word(), set_left == 0),
                1'b0, typed_total);
      sent++;
    end
    in_valid <= 1'b0;
    wait_idle();

    $display("Sent %0d sample beats over several register settings; checked %0d totals.",
             beats_sent, results_seen);
    if (errors == 0 && totals_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
